@@ rtl/brmt_pkg.sv @@
// Package for the branch register move tracker: command and error codes,
// default sizes and the in-flight entry type. No dependencies.
`default_nettype none
package brmt_pkg;
   localparam int NUM_BREGS_DEF    = 32;
   localparam int MAX_INFLIGHT_DEF = 32;
   localparam int SEQ_W  = 32;
   localparam int BREG_W = 5;

   typedef enum logic [2:0] {
      CMD_DECODE_MOVE  = 3'd0,
      CMD_DECODE_OTHER = 3'd1,
      CMD_EXECUTE      = 3'd2,
      CMD_COMMIT       = 3'd3,
      CMD_SQUASH       = 3'd4,
      CMD_QUERY        = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ERR_OK          = 3'd0,
      ERR_ORDER       = 3'd1,
      ERR_NOMATCH     = 3'd2,
      ERR_UNSUPPORTED = 3'd3,
      ERR_FULL        = 3'd4
   } err_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [BREG_W-1:0] breg;
      logic              bit_move;
      logic              executed;
      logic              squashed;
   } entry_type;

   // Per-cycle control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic             shift;     // take neighbor's entry (commit compaction)
      logic             rotate;    // walk: each cell passes entry down the row
      logic             load_tail; // write new entry at tail
      logic             squash;    // squash check in every cell
      logic [SEQ_W-1:0] seq;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_COMMIT, ST_SQUASH, ST_RESP
   } state_type;
endpackage
`default_nettype wire

@@ rtl/brmt_cell.sv @@
// One cell of the in-flight list: holds one entry and hands it to the
// neighbor below on a rotate or shift. Depends on brmt_pkg.
`default_nettype none
module brmt_cell
   import brmt_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         is_tail,
   input  wire entry_type    tail_entry,
   input  wire logic         mark_here,
   input  wire entry_type    from_next,
   output entry_type         entry
);
   entry_type entry_ff, entry_in;
   always_comb begin
      entry_in = entry_ff;
      if (ctl.rotate || ctl.shift) begin
         entry_in = from_next;
      end
      if (mark_here) begin
         entry_in.executed = 1'b1;
      end
      if (ctl.squash && entry_in.seq > ctl.seq) begin
         entry_in.squashed = 1'b1;
      end
      if (ctl.load_tail && is_tail) begin
         entry_in = tail_entry;
      end
   end
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
   assign entry = entry_ff;
endmodule
`default_nettype wire

@@ rtl/branch_register_move_tracker.sv @@
// Branch register move tracker: top level with the per-register tables,
// the sequencer and the row of list cells. Depends on brmt_pkg, brmt_cell.
//
// Scoreboard of in-flight moves into branch registers. One request item
// gives exactly one response item {stall_res, error}. Decode, query,
// unknown commands and early-failing commands are computed, then pass
// through the response register. Execute, commit and squash walk the
// in-flight list: the cells rotate one place per cycle so every entry
// passes cell 0, where it is checked, and a walk is one full rotation.
// Commit then shifts the list one place per dropped entry. Squash first
// walks to mark entries, then rebuilds the per-register maxima from the
// surviving entries one register per walk (NUM_BREGS walks).
// One item at a time; a finished response sits in the output register
// and req_tready is low while it waits, except in the cycle it is taken,
// when the next item can already be accepted. No clearing pass after reset.
`default_nettype none
module branch_register_move_tracker
   import brmt_pkg::*;
#(
   parameter int NUM_BREGS    = NUM_BREGS_DEF,
   parameter int MAX_INFLIGHT = MAX_INFLIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] command, [34:3] seq_num, [39:35] breg, [40] is_bit_move,
   // [41] is_precomputed_branch, [42] predicted_as_branch,
   // [43] inst_squashed, [44] breg_bits_ready, [47:45] zero
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] stall_res, [3:1] error, [7:4] zero
   output logic [7:0]       rsp_tdata
);
   localparam int RW = (NUM_BREGS > 1) ? $clog2(NUM_BREGS) : 1;
   localparam int CW = $clog2(MAX_INFLIGHT + 1);

   // request fields
   cmd_type           r_cmd;
   logic [SEQ_W-1:0]  r_seq;
   logic [BREG_W-1:0] r_breg;
   logic r_bit, r_pb, r_pred, r_sq, r_ready;
   assign r_cmd   = cmd_type'(req_tdata[2:0]);
   assign r_seq   = req_tdata[34:3];
   assign r_breg  = req_tdata[39:35];
   assign r_bit   = req_tdata[40];
   assign r_pb    = req_tdata[41];
   assign r_pred  = req_tdata[42];
   assign r_sq    = req_tdata[43];
   assign r_ready = req_tdata[44];

   // per-register tables, single write port each
   logic [SEQ_W-1:0] exec_tab_ff [NUM_BREGS];
   logic [SEQ_W-1:0] dec_tab_ff  [NUM_BREGS];
   logic [SEQ_W-1:0] full_tab_ff [NUM_BREGS];

   logic [SEQ_W-1:0] committed_ff, committed_in;
   logic [SEQ_W-1:0] any_ff, any_in;
   logic [CW-1:0]    count_ff, count_in;
   state_type        state_ff, state_in;
   logic [CW-1:0]    step_ff, step_in;      // walk position
   logic [CW-1:0]    drop_ff, drop_in;      // commit prefix length
   logic             hit_ff, hit_in;        // execute matched / commit prefix open
   logic [RW-1:0]    rreg_ff, rreg_in;      // squash rebuild register
   logic             rebuild_ff, rebuild_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [RW-1:0]    breg_ff, breg_in;
   logic [SEQ_W-1:0] mdec_ff, mdec_in, mfull_ff, mfull_in, mexec_ff, mexec_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             stall_ff, stall_in;
   err_type          err_ff, err_in;

   // table write port
   logic             tw_en;
   logic [RW-1:0]    tw_idx;
   logic             tw_dec, tw_full, tw_exec;
   logic [SEQ_W-1:0] tw_dec_v, tw_full_v, tw_exec_v;

   // cell row
   cell_ctl_type ctl;
   entry_type    tail_entry;
   entry_type    cells [MAX_INFLIGHT];
   logic         mark0;
   entry_type    head;
   assign head = cells[0];

   // the head entry leaves cell 0 into the last cell, so it is marked there
   for (genvar g = 0; g < MAX_INFLIGHT; g++) begin : g_cell
      entry_type nxt;
      logic      tail_here;
      if (g == MAX_INFLIGHT - 1) begin : g_last
         assign nxt = cells[0];
      end else begin : g_mid
         assign nxt = cells[g+1];
      end
      assign tail_here = (count_ff == CW'(g));
      brmt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .is_tail    (tail_here),
         .tail_entry (tail_entry),
         .mark_here  ((g == MAX_INFLIGHT - 1) && mark0),
         .from_next  (nxt),
         .entry      (cells[g])
      );
   end

   logic             breg_ok;
   logic [RW-1:0]    ridx;
   logic [SEQ_W-1:0] t_exec, t_dec, t_full;
   logic             head_live;
   logic             last_step;
   assign breg_ok   = (32'(r_breg) < 32'(NUM_BREGS));
   assign ridx      = RW'(r_breg);
   assign t_exec    = exec_tab_ff[ridx];
   assign t_dec     = dec_tab_ff[ridx];
   assign t_full    = full_tab_ff[ridx];
   assign head_live = (step_ff < count_ff);
   assign last_step = (step_ff == CW'(MAX_INFLIGHT - 1));

   always_comb begin
      state_in     = state_ff;
      committed_in = committed_ff;
      any_in       = any_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      drop_in      = drop_ff;
      hit_in       = hit_ff;
      rreg_in      = rreg_ff;
      rebuild_in   = rebuild_ff;
      seq_in       = seq_ff;
      breg_in      = breg_ff;
      mdec_in      = mdec_ff;
      mfull_in     = mfull_ff;
      mexec_in     = mexec_ff;
      rsp_valid_in = rsp_valid_ff;
      stall_in     = stall_ff;
      err_in       = err_ff;
      req_tready   = 1'b0;
      ctl          = '0;
      ctl.seq      = seq_ff;
      mark0        = 1'b0;
      tail_entry   = '0;
      tail_entry.seq      = r_seq;
      tail_entry.breg     = r_breg;
      tail_entry.bit_move = r_bit;
      tw_en = 1'b0; tw_idx = ridx;
      tw_dec = 1'b0; tw_full = 1'b0; tw_exec = 1'b0;
      tw_dec_v = r_seq; tw_full_v = r_seq; tw_exec_v = r_seq;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // output register is free, or is emptied at this edge
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               state_in = ST_RESP;
               stall_in = 1'b0;
               err_in   = ERR_OK;
               seq_in   = r_seq;
               breg_in  = ridx;
               step_in  = '0;
               drop_in  = '0;
               hit_in   = 1'b0;
               case (r_cmd)
                  CMD_DECODE_MOVE: begin
                     if (r_seq <= any_ff || !breg_ok || r_seq <= t_dec ||
                         (!r_bit && r_seq <= t_full)) begin
                        err_in = ERR_ORDER;
                     end else if (count_ff >= CW'(MAX_INFLIGHT)) begin
                        err_in = ERR_FULL;
                     end else begin
                        tw_en = 1'b1; tw_dec = 1'b1; tw_full = !r_bit;
                        ctl.load_tail = 1'b1;
                        count_in = count_ff + CW'(1);
                        any_in   = r_seq;
                     end
                  end
                  CMD_DECODE_OTHER: begin
                     if (r_seq <= any_ff) err_in = ERR_ORDER;
                     else any_in = r_seq;
                  end
                  CMD_EXECUTE: begin
                     if (!breg_ok || r_seq <= t_exec) err_in = ERR_ORDER;
                     else state_in = ST_EXEC;
                  end
                  CMD_COMMIT: begin
                     if (r_seq < committed_ff) begin
                        err_in = ERR_ORDER;
                     end else begin
                        committed_in = r_seq;
                        hit_in       = 1'b1;
                        state_in     = ST_COMMIT;
                     end
                  end
                  CMD_SQUASH: begin
                     rebuild_in = 1'b0;
                     rreg_in    = '0;
                     any_in     = committed_ff;
                     state_in   = ST_SQUASH;
                  end
                  CMD_QUERY: begin
                     if (r_sq || (!r_pb && !r_pred)) begin
                        stall_in = 1'b0;
                     end else if (!r_pb || !breg_ok) begin
                        err_in = ERR_UNSUPPORTED;
                     end else if (t_exec >= t_dec) begin
                        stall_in = 1'b0;
                     end else if (t_exec >= t_full) begin
                        stall_in = !r_ready;
                     end else begin
                        stall_in = 1'b1;
                     end
                  end
                  default: err_in = ERR_UNSUPPORTED;
               endcase
            end
         end
         // full rotation; first live entry with matching seq is marked
         ST_EXEC: begin
            ctl.rotate = 1'b1;
            if (head_live && !hit_ff && head.seq == seq_ff) begin
               mark0  = 1'b1;
               hit_in = 1'b1;
            end
            step_in = step_ff + CW'(1);
            if (last_step) begin
               state_in = ST_RESP;
               if (hit_in) begin
                  tw_en = 1'b1; tw_idx = breg_ff; tw_exec = 1'b1;
                  tw_exec_v = seq_ff;
               end else begin
                  err_in = ERR_NOMATCH;
               end
            end
         end
         // count the prefix during one rotation, then shift it out
         ST_COMMIT: begin
            if (!rebuild_ff) begin
               ctl.rotate = 1'b1;
               if (hit_ff && head_live && head.seq <= seq_ff) begin
                  drop_in = drop_ff + CW'(1);
               end else begin
                  hit_in = 1'b0;
               end
               step_in = step_ff + CW'(1);
               if (last_step) begin
                  rebuild_in = 1'b1;
                  step_in    = '0;
               end
            end else begin
               if (step_ff < drop_ff) begin
                  ctl.shift = 1'b1;
                  step_in   = step_ff + CW'(1);
               end else begin
                  count_in   = count_ff - drop_ff;
                  rebuild_in = 1'b0;
                  state_in   = ST_RESP;
               end
            end
         end
         // phase 0: mark pass; phase 1: per-register max rebuild
         ST_SQUASH: begin
            ctl.rotate = 1'b1;
            if (!rebuild_ff) begin
               ctl.squash = head_live;
               if (head_live && !(head.seq > seq_ff) && !head.squashed &&
                   32'(head.breg) < 32'(NUM_BREGS) && head.seq > any_ff) begin
                  any_in = head.seq;
               end
               step_in = step_ff + CW'(1);
               if (last_step) begin
                  rebuild_in = 1'b1;
                  step_in    = '0;
                  mdec_in = committed_ff; mfull_in = committed_ff;
                  mexec_in = committed_ff;
               end
            end else begin
               if (head_live && !head.squashed && head.breg == BREG_W'(rreg_ff)) begin
                  if (head.seq > mdec_ff) mdec_in = head.seq;
                  if (!head.bit_move && head.seq > mfull_ff) mfull_in = head.seq;
                  if (head.executed && head.seq > mexec_ff) mexec_in = head.seq;
               end
               step_in = step_ff + CW'(1);
               if (last_step) begin
                  tw_en = 1'b1; tw_idx = rreg_ff;
                  tw_dec = 1'b1; tw_full = 1'b1; tw_exec = 1'b1;
                  tw_dec_v = mdec_in; tw_full_v = mfull_in; tw_exec_v = mexec_in;
                  step_in  = '0;
                  mdec_in = committed_ff; mfull_in = committed_ff;
                  mexec_in = committed_ff;
                  if (32'(rreg_ff) == 32'(NUM_BREGS - 1)) begin
                     rebuild_in = 1'b0;
                     state_in   = ST_RESP;
                  end else begin
                     rreg_in = rreg_ff + RW'(1);
                  end
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         committed_ff <= '0;
         any_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rebuild_ff   <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         committed_ff <= committed_in;
         any_ff       <= any_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rebuild_ff   <= rebuild_in;
         hit_ff       <= hit_in;
      end
      step_ff  <= step_in;
      drop_ff  <= drop_in;
      rreg_ff  <= rreg_in;
      seq_ff   <= seq_in;
      breg_ff  <= breg_in;
      mdec_ff  <= mdec_in;
      mfull_ff <= mfull_in;
      mexec_ff <= mexec_in;
      stall_ff <= stall_in;
      err_ff   <= err_in;
   end

   // tables: reset to zero at once (small, one flop row per register)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BREGS; i++) begin
            exec_tab_ff[i] <= '0;
            dec_tab_ff[i]  <= '0;
            full_tab_ff[i] <= '0;
         end
      end else if (tw_en) begin
         if (tw_dec)  dec_tab_ff[tw_idx]  <= tw_dec_v;
         if (tw_full) full_tab_ff[tw_idx] <= tw_full_v;
         if (tw_exec) exec_tab_ff[tw_idx] <= tw_exec_v;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, err_ff, stall_ff};
endmodule
`default_nettype wire

@@ tb/tb_branch_register_move_tracker.sv @@
// Testbench for branch_register_move_tracker: directed table, list fill, random traffic.
// Depends on brmt_pkg and the RTL top level; checks every response against a local predictor.
`default_nettype none
module tb_branch_register_move_tracker;
   import brmt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NREG = NUM_BREGS_DEF;
   localparam int NLIST = MAX_INFLIGHT_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   branch_register_move_tracker i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Shadow scoreboard state, as after reset
   logic [31:0] sh_exec [NREG] = '{default: '0};
   logic [31:0] sh_dec [NREG] = '{default: '0};
   logic [31:0] sh_full [NREG] = '{default: '0};
   logic [31:0] sh_commit = '0;
   logic [31:0] sh_any = '0;
   entry_type   sh_list [$];

   typedef struct packed {
      logic    stall;
      err_type err;
   } rsp_type;

   rsp_type resp_q [$];
   int fail_cnt = 0;
   int item_cnt = 0;
   int resp_cnt = 0;

   function automatic logic [47:0] pack_req(cmd_type c, logic [31:0] s, logic [4:0] r,
                                            logic [4:0] flags);
      return {3'b000, flags, r, s, c};
   endfunction

   // One-step behavior of the tracker; updates shadow state.
   function automatic rsp_type track_step(logic [47:0] d);
      logic [2:0]  c = d[2:0];
      logic [31:0] s = d[34:3];
      int          r = d[39:35];
      logic        bitm = d[40], pb = d[41], pred = d[42], sq = d[43], rdy = d[44];
      rsp_type     o;
      entry_type   e;
      o.stall = 1'b0;
      o.err = ERR_OK;
      case (c)
         CMD_DECODE_MOVE, CMD_DECODE_OTHER: begin
            if (s <= sh_any) o.err = ERR_ORDER;
            else if (c == CMD_DECODE_MOVE) begin
               if (r >= NREG || s <= sh_dec[r] || (!bitm && s <= sh_full[r]))
                  o.err = ERR_ORDER;
               else if (sh_list.size() >= NLIST) o.err = ERR_FULL;
               else begin
                  sh_dec[r] = s;
                  if (!bitm) sh_full[r] = s;
                  e.seq = s; e.breg = 5'(r); e.bit_move = bitm;
                  e.executed = 0; e.squashed = 0;
                  sh_list = {sh_list, e};
               end
            end
            if (o.err == ERR_OK) sh_any = s;
         end
         CMD_EXECUTE: begin
            if (r >= NREG || s <= sh_exec[r]) o.err = ERR_ORDER;
            else begin
               o.err = ERR_NOMATCH;
               foreach (sh_list[i]) begin
                  if (o.err == ERR_NOMATCH && sh_list[i].seq == s) begin
                     sh_exec[r] = s;
                     sh_list[i].executed = 1'b1;
                     o.err = ERR_OK;
                  end
               end
            end
         end
         CMD_COMMIT: begin
            if (s < sh_commit) o.err = ERR_ORDER;
            else begin
               sh_commit = s;
               while (sh_list.size() > 0 && sh_list[0].seq <= s) void'(sh_list.pop_front());
            end
         end
         CMD_SQUASH: begin
            foreach (sh_list[i]) if (sh_list[i].seq > s) sh_list[i].squashed = 1'b1;
            for (int k = 0; k < NREG; k++) begin
               sh_dec[k] = sh_commit; sh_full[k] = sh_commit; sh_exec[k] = sh_commit;
            end
            sh_any = sh_commit;
            foreach (sh_list[i]) begin
               e = sh_list[i];
               if (!e.squashed && e.breg < NREG) begin
                  if (e.seq > sh_dec[e.breg]) sh_dec[e.breg] = e.seq;
                  if (!e.bit_move && e.seq > sh_full[e.breg]) sh_full[e.breg] = e.seq;
                  if (e.executed && e.seq > sh_exec[e.breg]) sh_exec[e.breg] = e.seq;
                  if (e.seq > sh_any) sh_any = e.seq;
               end
            end
         end
         CMD_QUERY: begin
            if (sq || (!pb && !pred)) o.err = ERR_OK;
            else if (!pb || r >= NREG) o.err = ERR_UNSUPPORTED;
            else if (sh_exec[r] >= sh_dec[r]) o.stall = 1'b0;
            else if (sh_exec[r] >= sh_full[r]) o.stall = !rdy;
            else o.stall = 1'b1;
         end
         default: o.err = ERR_UNSUPPORTED;
      endcase
      if (o.err != ERR_OK) o.stall = 1'b0;
      return o;
   endfunction

   // Well-formed traffic drawn from the shadow state, plus some noise.
   function automatic logic [47:0] gen_item();
      int          p = $urandom_range(99);
      logic [31:0] s;
      logic [4:0]  r = ($urandom_range(1)) ? 5'($urandom_range(3)) : 5'($urandom);
      logic [4:0]  fl = 5'($urandom);
      int          n = sh_list.size();
      if (p < 30) begin
         s = sh_any + $urandom_range(1, 4);
         return pack_req(CMD_DECODE_MOVE, s, r, fl);
      end else if (p < 40) begin
         return pack_req(CMD_DECODE_OTHER, sh_any + $urandom_range(1, 4), r, fl);
      end else if (p < 60) begin
         if (n > 0) begin
            s = sh_list[$urandom_range(n - 1)].seq;
            if ($urandom_range(3) != 0) r = sh_list[$urandom_range(n - 1)].breg;
            foreach (sh_list[i]) if (sh_list[i].seq == s && $urandom_range(4) != 0)
               r = sh_list[i].breg;
         end else s = sh_any;
         return pack_req(CMD_EXECUTE, s, r, fl);
      end else if (p < 68) begin
         s = (n > 0) ? sh_list[$urandom_range(n - 1)].seq : sh_any;
         if (s < sh_commit) s = sh_commit;
         return pack_req(CMD_COMMIT, s, r, fl);
      end else if (p < 71) begin
         s = (n > 0) ? sh_list[$urandom_range(n - 1)].seq : sh_commit;
         return pack_req(CMD_SQUASH, s, r, fl);
      end else if (p < 93) begin
         // precomputed branch most of the time
         if ($urandom_range(3) != 0) begin fl[1] = 1'b1; fl[3] = ($urandom_range(5) == 0); end
         return pack_req(CMD_QUERY, 32'($urandom), r, fl);
      end else begin
         // noise; commits go backwards so the boundary never runs off
         logic [47:0] d = {3'b000, 45'({$urandom, $urandom})};
         if (d[2:0] == CMD_COMMIT)
            d[34:3] = (sh_commit > 3) ? sh_commit - $urandom_range(1, 3) : 32'd0;
         return d;
      end
   endfunction

   // Offer one item; gaps at random outside the quiet stretch.
   task automatic send_item(logic [47:0] d, logic known, rsp_type want);
      rsp_type got;
      if ((item_cnt < 100 || item_cnt > 250) && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      got = track_step(d);
      if (known) got = want;
      resp_q = {resp_q, got};
      item_cnt++;
   endtask

   // Directed rows: typed expectation only where obvious
   typedef struct {
      logic [47:0] d;
      logic        known;
      rsp_type     want;
   } row_type;

   row_type rows [$];

   task automatic add_row(cmd_type c, logic [31:0] s, logic [4:0] r, logic [4:0] fl,
                          logic known = 0, logic st = 0, err_type e = ERR_OK);
      row_type x;
      x.d = pack_req(c, s, r, fl);
      x.known = known;
      x.want.stall = st;
      x.want.err = e;
      rows = {rows, x};
   endtask

   initial begin
      // flags: [0] bit move, [1] precomputed, [2] predicted, [3] squashed, [4] bits ready
      add_row(CMD_QUERY, 0, 0, 5'b00010, 1, 0, ERR_OK);          // empty after reset
      add_row(cmd_type'(3'd6), 0, 0, 0, 1, 0, ERR_UNSUPPORTED);
      add_row(cmd_type'(3'd7), 32'hFFFF_FFFF, 31, 5'b11111, 1, 0, ERR_UNSUPPORTED);
      add_row(CMD_DECODE_MOVE, 0, 0, 0, 1, 0, ERR_ORDER);        // not above zero
      add_row(CMD_EXECUTE, 5, 3, 0, 1, 0, ERR_NOMATCH);
      add_row(CMD_COMMIT, 0, 0, 0);
      add_row(CMD_DECODE_MOVE, 10, 31, 0);
      add_row(CMD_QUERY, 0, 31, 5'b00010);
      add_row(CMD_DECODE_MOVE, 11, 31, 5'b00001);                // bit move
      add_row(CMD_EXECUTE, 10, 31, 0);
      add_row(CMD_QUERY, 0, 31, 5'b00010);                       // bits not ready
      add_row(CMD_QUERY, 0, 31, 5'b10010);                       // bits ready
      add_row(CMD_QUERY, 0, 31, 5'b01010, 1, 0, ERR_OK);         // already squashed
      add_row(CMD_QUERY, 0, 31, 5'b00100, 1, 0, ERR_UNSUPPORTED);// mispredicted non-branch
      add_row(CMD_QUERY, 0, 31, 5'b00000, 1, 0, ERR_OK);
      add_row(CMD_DECODE_OTHER, 11, 0, 0, 1, 0, ERR_ORDER);
      add_row(CMD_EXECUTE, 10, 31, 0, 1, 0, ERR_ORDER);          // executed again
      add_row(CMD_DECODE_OTHER, 32'hFFFF_FFFF, 0, 0);
      add_row(CMD_SQUASH, 10, 0, 0);                             // drops the max back
      add_row(CMD_EXECUTE, 11, 31, 0);                           // squashed entry still hit
      add_row(CMD_COMMIT, 5, 0, 0);
      add_row(CMD_COMMIT, 3, 0, 0, 1, 0, ERR_ORDER);             // backwards
      add_row(CMD_COMMIT, 11, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_item(rows[i].d, rows[i].known, rows[i].want);
      // fill the list past its depth
      for (int k = 0; k < NLIST + 2; k++)
         send_item(pack_req(CMD_DECODE_MOVE, sh_any + 1, 5'(k), 5'($urandom)), 0, '0);
      for (int k = 0; k < 750; k++) begin
         if (k == 400) begin
            req_tvalid <= 1'b0;
            wait (resp_q.size() == 0);
            @(posedge clock);
         end
         send_item(gen_item(), 0, '0);
      end
      // boundary at the top end, then nothing may go past it
      send_item(pack_req(CMD_COMMIT, 32'hFFFF_FFFF, 0, 0), 0, '0);
      send_item(pack_req(CMD_DECODE_MOVE, 32'hFFFF_FFFF, 1, 0), 0, '0);
      send_item(pack_req(CMD_COMMIT, 0, 0, 0), 0, '0);
      req_tvalid <= 1'b0;
      wait (resp_q.size() == 0);
      repeat (50) @(posedge clock);
      if (fail_cnt == 0 && resp_q.size() == 0) begin
         $display("PASS branch_register_move_tracker");
      end else begin
         $display("FAIL branch_register_move_tracker");
      end
      $finish;
   end

   // Response side: random back-pressure, one long hold-off, field checks.
   initial begin
      int hold = 0;
      logic held = 1'b0;
      rsp_type w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (resp_q.size() == 0) begin
               $error("response item with nothing expected: %h", rsp_tdata);
               fail_cnt++;
            end else begin
               w = resp_q.pop_front();
               if (rsp_tdata[0] !== w.stall) begin
                  $error("stall_res: expected %0d, got %0d", w.stall, rsp_tdata[0]);
                  fail_cnt++;
               end
               if (rsp_tdata[3:1] !== w.err) begin
                  $error("error: expected %0d, got %0d", w.err, rsp_tdata[3:1]);
                  fail_cnt++;
               end
            end
            resp_cnt++;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!held && resp_cnt >= 200) begin
            held = 1'b1;
            hold = 300;
            rsp_tready <= 1'b0;
         end else if (resp_cnt >= 100 && resp_cnt <= 250) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 8);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("FAIL branch_register_move_tracker");
      $finish;
   end
endmodule
`default_nettype wire
